FILE: rtl/gyro_attitude_integrator_core_assert.svh
// ----------------------------------------------------------------------------
// gyro_attitude_integrator_core_assert.svh
// Assertion macros for the attitude integrator core.
// ----------------------------------------------------------------------------
`ifndef GYRO_ATTITUDE_INTEGRATOR_CORE_ASSERT_SVH
`define GYRO_ATTITUDE_INTEGRATOR_CORE_ASSERT_SVH

// Same-cycle implication, reset masked
`define GAI_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("attitude integrator check failed");

// Next-cycle implication, reset masked
`define GAI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("attitude integrator check failed");

`endif

FILE: rtl/gai_pkg.sv
// ----------------------------------------------------------------------------
// gai_pkg
// Types, constants and term table of the attitude integrator.
// ----------------------------------------------------------------------------
package gai_pkg;

	localparam logic        CMD_INTEGRATE = 1'b0;
	localparam logic        CMD_LOAD      = 1'b1;
	localparam logic        REG_STEP_TIME = 1'b0;
	localparam logic [15:0] STEP_TIME_RST = 16'd66;
	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

	typedef struct packed {
		logic               command;
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_z;
		logic signed [15:0] load_w;
		logic signed [15:0] load_x;
		logic signed [15:0] load_y;
		logic signed [15:0] load_z;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] att_w;
		logic signed [15:0] att_x;
		logic signed [15:0] att_y;
		logic signed [15:0] att_z;
	} out_item_t;

	// One product term of the quaternion rate: sign, attitude and rate pick
	typedef struct packed {
		logic       neg;
		logic [1:0] att_sel;
		logic [1:0] rate_sel;
	} term_t;

	// Term j of component i of q * (0, rate)
	function automatic term_t term_lookup(input logic [1:0] comp, input logic [1:0] tj);
		term_t t;
		case ({comp, tj})
			4'h0:    t = '{1'b1, 2'd1, 2'd0};
			4'h1:    t = '{1'b1, 2'd2, 2'd1};
			4'h2:    t = '{1'b1, 2'd3, 2'd2};
			4'h4:    t = '{1'b0, 2'd0, 2'd0};
			4'h5:    t = '{1'b0, 2'd2, 2'd2};
			4'h6:    t = '{1'b1, 2'd3, 2'd1};
			4'h8:    t = '{1'b0, 2'd0, 2'd1};
			4'h9:    t = '{1'b1, 2'd1, 2'd2};
			4'hA:    t = '{1'b0, 2'd3, 2'd0};
			4'hC:    t = '{1'b0, 2'd0, 2'd2};
			4'hD:    t = '{1'b0, 2'd1, 2'd1};
			4'hE:    t = '{1'b1, 2'd2, 2'd0};
			default: t = '{1'b0, 2'd0, 2'd0};
		endcase
		return t;
	endfunction

endpackage

FILE: rtl/gyro_attitude_integrator_core.sv
// ----------------------------------------------------------------------------
// gyro_attitude_integrator_core
// First-order quaternion attitude integrator with normalization.
// ----------------------------------------------------------------------------
// One item at a time. An integrate transaction goes from acceptance to result
// through issue and accumulate on the one shared multiplier (12 rate
// products, 4 step scalings, 4 squares), the bit-serial square root and a
// step to round it, the bit-serial divider for each component (skipped, with
// the identity attitude, for a zero magnitude), and the hand-over of the
// result. A load transaction goes straight to the hand-over. in_stall stays
// high while an item is worked on and drops the cycle after the hand-over; a
// new item is taken while a finished result waits on out_stall.
module gyro_attitude_integrator_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  gai_pkg::in_item_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output gai_pkg::out_item_t out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import gai_pkg::*;
	`include "gyro_attitude_integrator_core_assert.svh"

	typedef enum logic [3:0] {
		ST_IDLE, ST_PROD, ST_SCALE, ST_SQUARE, ST_SQRT, ST_SQRT_RND,
		ST_DIV_INIT, ST_DIV, ST_DIV_FIN, ST_FINISH
	} state_t;

	state_t             state_q;
	logic               ph_q;
	logic [4:0]         cnt_q;
	logic [1:0]         comp_q;
	logic [15:0]        step_time_q;
	logic signed [15:0] att_q  [4];
	logic signed [15:0] rate_q [3];
	logic signed [33:0] acc_q  [4];
	logic signed [27:0] s_q    [4];
	logic [55:0]        sumsq_q;
	logic [63:0]        rem_q;
	logic [63:0]        root_q;
	logic [31:0]        mag_q;
	logic [46:0]        drem_q;
	logic [17:0]        quo_q;
	logic               neg_q;
	logic signed [55:0] prod_q;
	logic               out_valid_q;
	out_item_t          out_data_q;

	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] mul_full;
	term_t              term;
	logic [55:0]        rnd_mag;
	logic [33:0]        rnd_q;
	logic signed [27:0] inc;
	logic signed [27:0] s_new;
	logic [55:0]        sumsq_next;
	logic [63:0]        sq_bit;
	logic [63:0]        sq_trial;
	logic [31:0]        mag_next;
	logic signed [45:0] num;
	logic [45:0]        num_mag;
	logic [48:0]        den_sh;
	logic [17:0]        quo_neg;
	logic signed [15:0] div_res;
	logic               cfg_wr;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr[2] == REG_STEP_TIME) ? {16'd0, step_time_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_time_q <= STEP_TIME_RST;
		end else if (cfg_wr && paddr[2] == REG_STEP_TIME) begin
			step_time_q <= pwdata[15:0];
		end
	end

	// Select operands of the shared multiplier
	assign term = term_lookup(comp_q, cnt_q[1:0]);
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_PROD: begin
				mul_a = 34'(att_q[term.att_sel]);
				mul_b = 34'(rate_q[term.rate_sel]);
			end
			ST_SCALE: begin
				mul_a = acc_q[comp_q];
				mul_b = {18'd0, step_time_q};
			end
			ST_SQUARE: begin
				mul_a = 34'(s_q[comp_q]);
				mul_b = 34'(s_q[comp_q]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_full = mul_a * mul_b;

	// Round scaled increment to 20 fraction bits, half away from zero
	always_comb begin
		rnd_mag = prod_q[55] ? 56'(56'sd0 - prod_q) : prod_q;
		rnd_q   = 34'((rnd_mag + (56'd1 << 21)) >> 22);
		inc     = prod_q[55] ? 28'(34'd0 - rnd_q) : rnd_q[27:0];
		s_new   = {{6{att_q[comp_q][15]}}, att_q[comp_q], 6'd0} + inc;
	end

	assign sumsq_next = sumsq_q + prod_q;

	// Square root trial and rounding
	assign sq_bit   = 64'd1 << {cnt_q, 1'b0};
	assign sq_trial = root_q + sq_bit;
	assign mag_next = root_q[31:0] + ((rem_q > root_q) ? 32'd1 : 32'd0);

	// Divider operands and saturating result
	always_comb begin
		num     = {s_q[comp_q], 18'd0};
		num_mag = num[45] ? 46'(46'sd0 - num) : num;
		den_sh  = 49'(mag_q) << cnt_q;
		quo_neg = 18'd0 - quo_q;
		if (!neg_q) begin
			div_res = (quo_q > 18'd32767) ? 16'sh7FFF : quo_q[15:0];
		end else begin
			div_res = (quo_q > 18'd32768) ? 16'sh8000 : quo_neg[15:0];
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	// Sequencer with shared multiplier, root and divide steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ph_q        <= 1'b0;
			cnt_q       <= '0;
			comp_q      <= '0;
			out_valid_q <= 1'b0;
			att_q[0]    <= ONE_Q14;
			att_q[1]    <= '0;
			att_q[2]    <= '0;
			att_q[3]    <= '0;
		end else begin
			prod_q <= mul_full[55:0];
			// Drop the result once taken, unless a new one is handed over now
			if (out_valid_q && !out_stall && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_data.command == CMD_LOAD) begin
							att_q[0] <= in_data.load_w;
							att_q[1] <= in_data.load_x;
							att_q[2] <= in_data.load_y;
							att_q[3] <= in_data.load_z;
							state_q  <= ST_FINISH;
						end else begin
							rate_q[0] <= in_data.rate_x;
							rate_q[1] <= in_data.rate_y;
							rate_q[2] <= in_data.rate_z;
							for (int i = 0; i < 4; i++) acc_q[i] <= '0;
							sumsq_q <= '0;
							ph_q    <= 1'b0;
							cnt_q   <= '0;
							comp_q  <= '0;
							state_q <= ST_PROD;
						end
					end
				end
				ST_PROD: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						acc_q[comp_q] <= term.neg ? acc_q[comp_q] - prod_q[33:0]
						                          : acc_q[comp_q] + prod_q[33:0];
						if (cnt_q[1:0] == 2'd2) begin
							cnt_q  <= '0;
							comp_q <= comp_q + 2'd1;
							if (comp_q == 2'd3) state_q <= ST_SCALE;
						end else begin
							cnt_q <= cnt_q + 5'd1;
						end
					end
				end
				ST_SCALE: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						s_q[comp_q] <= s_new;
						comp_q      <= comp_q + 2'd1;
						if (comp_q == 2'd3) state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						sumsq_q <= sumsq_next;
						comp_q  <= comp_q + 2'd1;
						if (comp_q == 2'd3) begin
							rem_q   <= {sumsq_next, 8'd0};
							root_q  <= '0;
							cnt_q   <= 5'd31;
							state_q <= ST_SQRT;
						end
					end
				end
				ST_SQRT: begin
					if (rem_q >= sq_trial) begin
						rem_q  <= rem_q - sq_trial;
						root_q <= (root_q >> 1) + sq_bit;
					end else begin
						root_q <= root_q >> 1;
					end
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) state_q <= ST_SQRT_RND;
				end
				ST_SQRT_RND: begin
					mag_q  <= mag_next;
					comp_q <= '0;
					if (mag_next == 32'd0) begin
						att_q[0] <= ONE_Q14;
						att_q[1] <= '0;
						att_q[2] <= '0;
						att_q[3] <= '0;
						state_q  <= ST_FINISH;
					end else begin
						state_q <= ST_DIV_INIT;
					end
				end
				ST_DIV_INIT: begin
					neg_q   <= num[45];
					drem_q  <= 47'(num_mag) + 47'(mag_q >> 1);
					quo_q   <= '0;
					cnt_q   <= 5'd17;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (49'(drem_q) >= den_sh) begin
						drem_q <= 47'(49'(drem_q) - den_sh);
						quo_q  <= {quo_q[16:0], 1'b1};
					end else begin
						quo_q  <= {quo_q[16:0], 1'b0};
					end
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) state_q <= ST_DIV_FIN;
				end
				ST_DIV_FIN: begin
					att_q[comp_q] <= div_res;
					comp_q        <= comp_q + 2'd1;
					state_q       <= (comp_q == 2'd3) ? ST_FINISH : ST_DIV_INIT;
				end
				ST_FINISH: begin
					// Hand over once the output register is free
					if (!out_valid_q || !out_stall) begin
						out_data_q  <= '{att_q[0], att_q[1], att_q[2], att_q[3]};
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`GAI_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`GAI_ASSERT_NEXT(a_sqrt_ends, state_q == ST_SQRT && cnt_q == 5'd0, state_q == ST_SQRT_RND)
	`GAI_ASSERT_NOW(a_finish_holds, state_q == ST_FINISH && out_valid_q && out_stall, in_stall)

endmodule
